// ===== rtl/unsigned_to_radix_text_unit_macros.svh =====
// Assertion macros shared by the unsigned-to-radix-text RTL.
`ifndef UNSIGNED_TO_RADIX_TEXT_UNIT_MACROS_SVH
`define UNSIGNED_TO_RADIX_TEXT_UNIT_MACROS_SVH

// Implication checked on the same edge, disabled while in reset.
`define U2RT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge, disabled while in reset.
`define U2RT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u2rt_pkg.sv =====
// Package: types, codes and constants of the unsigned-to-radix-text unit.
package u2rt_pkg;

  localparam int unsigned DEF_WORD_BITS = 32;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CHAR_W        = 7;

  typedef enum logic [1:0] {
    FMT_DEC    = 2'd0,
    FMT_OCT    = 2'd1,
    FMT_HEX_LO = 2'd2,
    FMT_HEX_UP = 2'd3
  } fmt_e;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;    // capture a new item
    logic dabble;  // one shift-add-3 step of the binary to BCD conversion
    logic skip;    // drop a leading zero digit
    logic emit;    // move the current digit into the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_dec;     // item at the input asks for decimal
    logic conv_done;  // this dabble step is the final one
    logic lead_zero;  // current digit is a leading zero that can be dropped
    logic final_dig;  // current digit is the last of the number
    logic out_free;   // output register can take a digit this cycle
  } sts_t;

endpackage

// ===== rtl/u2rt_ctrl.sv =====
// Controller: sequences load, BCD conversion and digit emission.
module u2rt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  u2rt_pkg::sts_t  sts_i,
  output u2rt_pkg::cmd_t  cmd_o
);
  import u2rt_pkg::*;

  `include "unsigned_to_radix_text_unit_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_dec ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.lead_zero) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_dig) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `U2RT_ASSERT_NXT(a_last_digit_idles, cmd_o.emit && sts_i.final_dig, state_q == ST_IDLE,
                   "controller did not return to idle after the last digit")
  `U2RT_ASSERT_IMP(a_skip_not_final, cmd_o.skip, !sts_i.final_dig,
                   "final digit was dropped as a leading zero")

endmodule

// ===== rtl/u2rt_dpath.sv =====
// Datapath: binary to BCD shifter, digit shift register and output register.
module u2rt_dpath #(
  parameter int unsigned WordBits = u2rt_pkg::DEF_WORD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u2rt_pkg::req_t  in_req_i,
  input  u2rt_pkg::cmd_t  cmd_i,
  output u2rt_pkg::sts_t  sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output u2rt_pkg::rsp_t  out_rsp_o
);
  import u2rt_pkg::*;

  `include "unsigned_to_radix_text_unit_macros.svh"

  // Digit counts; 0.302 slightly overestimates log10(2), so BCD never overflows
  localparam int unsigned DecDigits = (WordBits * 302) / 1000 + 1;
  localparam int unsigned OctDigits = (WordBits + 2) / 3;
  localparam int unsigned HexDigits = (WordBits + 3) / 4;
  localparam int unsigned SrW       = (4 * DecDigits >= 3 * OctDigits) ?
                                      4 * DecDigits : 3 * OctDigits;
  localparam int unsigned MaxDigits = (DecDigits >= OctDigits) ? DecDigits : OctDigits;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned StepW     = (WordBits > 1) ? $clog2(WordBits) : 1;

  logic [WordBits-1:0] val_w;
  logic [WordBits-1:0] bin_q;
  logic [SrW-1:0]      sr_q, sr_adj;
  fmt_e                fmt_q, fmt_in;
  logic [StepW-1:0]    step_q;
  logic [CntW-1:0]     cnt_q;
  logic                started_q;
  logic                out_valid_q;
  rsp_t                out_q;
  logic [3:0]          digit;
  logic [CHAR_W-1:0]   char_code;

  if (WordBits <= VALUE_W) begin : g_narrow
    assign val_w = in_req_i.value[WordBits-1:0];
  end else begin : g_wide
    assign val_w = {{(WordBits - VALUE_W){1'b0}}, in_req_i.value};
  end

  assign fmt_in = fmt_e'(in_req_i.req_type);

  // Most significant digit sits at a fixed place per format
  always_comb begin
    case (fmt_q)
      FMT_DEC: digit = sr_q[4*DecDigits-1 -: 4];
      FMT_OCT: digit = {1'b0, sr_q[3*OctDigits-1 -: 3]};
      default: digit = sr_q[4*HexDigits-1 -: 4];
    endcase
  end

  always_comb begin
    if (digit < 4'd10) begin
      char_code = CHAR_ZERO + CHAR_W'(digit);
    end else if (fmt_q == FMT_HEX_UP) begin
      char_code = CHAR_UPPER_A + CHAR_W'(digit - 4'd10);
    end else begin
      char_code = CHAR_LOWER_A + CHAR_W'(digit - 4'd10);
    end
  end

  // Add 3 to every BCD digit of 5 or more ahead of the shift
  always_comb begin
    sr_adj = sr_q;
    for (int i = 0; i < DecDigits; i++) begin
      if (sr_q[4*i +: 4] >= 4'd5) begin
        sr_adj[4*i +: 4] = sr_q[4*i +: 4] + 4'd3;
      end
    end
  end

  assign sts_o.in_dec    = (fmt_in == FMT_DEC);
  assign sts_o.conv_done = (step_q == StepW'(WordBits - 1));
  assign sts_o.final_dig = (cnt_q == CntW'(1));
  assign sts_o.lead_zero = (digit == 4'd0) && !started_q && (cnt_q != CntW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fmt_q <= fmt_in;
      bin_q <= val_w;
      sr_q  <= (fmt_in == FMT_DEC) ? '0 : SrW'(val_w);
    end else if (cmd_i.dabble) begin
      sr_q  <= {sr_adj[SrW-2:0], bin_q[WordBits-1]};
      bin_q <= bin_q << 1;
    end else if (cmd_i.skip || cmd_i.emit) begin
      sr_q  <= (fmt_q == FMT_OCT) ? (sr_q << 3) : (sr_q << 4);
    end
    if (cmd_i.emit) begin
      out_q.char_code <= char_code;
      out_q.last      <= sts_o.final_dig;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q    <= '0;
        started_q <= 1'b0;
        case (fmt_in)
          FMT_DEC: cnt_q <= CntW'(DecDigits);
          FMT_OCT: cnt_q <= CntW'(OctDigits);
          default: cnt_q <= CntW'(HexDigits);
        endcase
      end else begin
        if (cmd_i.dabble) begin
          step_q <= step_q + StepW'(1);
        end
        if (cmd_i.skip || cmd_i.emit) begin
          cnt_q <= cnt_q - CntW'(1);
        end
        if (cmd_i.emit) begin
          started_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `U2RT_ASSERT_IMP(a_dabble_not_started, cmd_i.dabble, !started_q,
                   "BCD step while digits are already being sent")
  `U2RT_ASSERT_IMP(a_emit_has_room, cmd_i.emit, !out_valid_q || out_ready_i,
                   "digit overwrote an unsent item")

endmodule

// ===== rtl/unsigned_to_radix_text_unit.sv =====
// Top level: unsigned number to ASCII digits in decimal, octal or hex.
//
// Input channel (in_valid_i / in_ready_o, payload in_req_i): one item is a
// number and a format (decimal, octal, lowercase hex, uppercase hex).
// Output channel (out_valid_o / out_ready_i, payload out_rsp_o): one item per
// ASCII digit, most significant first, no leading zeros; zero gives "0".
// The final digit of a number carries last = 1.
// One number is handled at a time; in_ready_o is high only while idle.
// Decimal: a shift-add-3 loop (binary to BCD) runs first, then the unit walks
// each BCD digit place (DecDigits places, 10 at 32 bits), dropped leading
// zeros included. Octal and hex skip the BCD loop and walk their 11 or 8
// digit places directly.
// A registered output stage holds the waiting digit; a stalled receiver
// freezes emission, and the next number is taken while the last digit waits.
// Reset (rst_ni low, asynchronous) returns to idle and drops any digit held.
module unsigned_to_radix_text_unit #(
  parameter int unsigned WordBits = u2rt_pkg::DEF_WORD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  u2rt_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output u2rt_pkg::rsp_t  out_rsp_o
);
  import u2rt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  u2rt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  u2rt_dpath #(
    .WordBits (WordBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== tb/unsigned_to_radix_text_unit_test.sv =====
// Testbench for the unsigned-to-radix-text unit: directed and random numbers checked per digit.
`timescale 1ns / 100ps

module unsigned_to_radix_text_unit_test;
  import u2rt_pkg::*;

  localparam int unsigned WORD_BITS    = DEF_WORD_BITS;
  localparam logic [63:0] RADIX_DEC    = 64'd10;
  localparam logic [63:0] RADIX_OCT    = 64'd8;
  localparam logic [63:0] RADIX_HEX    = 64'd16;
  localparam int unsigned RANDOM_ITEMS = 320;
  // Worst case per item: the conversion, 11 digits each stalled by the
  // receiver, plus a sender gap. Taken several times over.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 64;

  // Expected digit stream of every accepted number, oldest first.
  class digit_scoreboard;
    rsp_t digits_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Works out the ASCII digits of an accepted number and queues them.
    function void note_number(req_t req);
      logic [63:0] rest;
      logic [63:0] place;
      logic [63:0] radix;
      logic [63:0] digit;
      logic [31:0] mask;
      fmt_e        fmt;
      rsp_t        exp_digit;
      fmt  = fmt_e'(req.req_type);
      mask = (WORD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << WORD_BITS) - 64'd1);
      rest = 64'(req.value & mask);
      case (fmt)
        FMT_DEC: radix = RADIX_DEC;
        FMT_OCT: radix = RADIX_OCT;
        default: radix = RADIX_HEX;
      endcase
      // Weight of the leading digit; zero still yields one digit.
      place = 64'd1;
      while (rest / place >= radix) place = place * radix;
      while (place != 0) begin
        digit = rest / place;
        rest  = rest % place;
        place = place / radix;
        if (digit < 10)
          exp_digit.char_code = CHAR_ZERO + CHAR_W'(digit);
        else if (fmt == FMT_HEX_UP)
          exp_digit.char_code = CHAR_UPPER_A + CHAR_W'(digit - 10);
        else
          exp_digit.char_code = CHAR_LOWER_A + CHAR_W'(digit - 10);
        exp_digit.last = (place == 0);
        digits_q.push_back(exp_digit);
      end
    endfunction

    // Compares one delivered digit with the oldest expected one.
    function void check_digit(rsp_t got);
      rsp_t exp_digit;
      if (digits_q.size() == 0) begin
        $error("unexpected digit item: char_code %h last %b", got.char_code, got.last);
        errors++;
        return;
      end
      exp_digit = digits_q.pop_front();
      if (got.char_code !== exp_digit.char_code) begin
        $error("char_code: expected %h, actual %h", exp_digit.char_code, got.char_code);
        errors++;
      end
      if (got.last !== exp_digit.last) begin
        $error("last: expected %b, actual %b", exp_digit.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return digits_q.size();
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  digit_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     burst_left  = 0;

  // Receiver stall state, owned by the receiver process only.
  int unsigned     stall_mode  = 0;
  int unsigned     stall_tick  = 0;
  int unsigned     stall_hold  = 0;

  unsigned_to_radix_text_unit #(
    .WordBits(WORD_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop if the block hangs or loses digits.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: checks each accepted digit item, then picks next ready.
  // Modes, redrawn periodically at random: always ready, coin flip, fixed
  // pattern, or long random stalls.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_digit(out_rsp_o);
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (stall_tick % 5 != 0) && (stall_tick % 7 != 3);
      default: begin
        if (stall_hold != 0) begin
          stall_hold--;
          out_ready_i <= 1'b0;
        end else begin
          stall_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
          out_ready_i <= (stall_hold == 0);
        end
      end
    endcase
  end

  function automatic req_t make_req(fmt_e fmt, logic [VALUE_W-1:0] value);
    req_t req;
    req.req_type = fmt;
    req.value    = value;
    return req;
  endfunction

  // Random number, weighted toward digit-count boundaries and short values.
  function automatic req_t random_req();
    fmt_e        fmt;
    logic [63:0] power;
    logic [63:0] radix;
    int unsigned steps;
    logic [31:0] value;
    fmt = fmt_e'($urandom_range(0, 3));
    case (fmt)
      FMT_DEC: radix = RADIX_DEC;
      FMT_OCT: radix = RADIX_OCT;
      default: radix = RADIX_HEX;
    endcase
    case ($urandom_range(0, 5))
      0, 1: value = $urandom;
      2:    value = $urandom_range(0, 20);
      3:    value = $urandom >> $urandom_range(0, 31);
      4: begin
        // Neighbors of a power of the radix: digit count steps here.
        power = 64'd1;
        steps = $urandom_range(1, 11);
        repeat (steps) if (power * radix <= 64'hFFFF_FFFF) power = power * radix;
        value = 32'(power) - 32'($urandom_range(0, 1));
      end
      default: value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
    endcase
    return make_req(fmt, value);
  endfunction

  // Sender: items go out in bursts with random gaps in between.
  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_number(req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_number(req);
  endtask

  initial begin
    req_t directed_q[$];
    sb = new();

    // Reset held at the start, once.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero and all-ones per format, digit-count edges, mixed letters.
    directed_q.push_back(make_req(FMT_DEC,    32'd0));
    directed_q.push_back(make_req(FMT_OCT,    32'd0));
    directed_q.push_back(make_req(FMT_HEX_LO, 32'd0));
    directed_q.push_back(make_req(FMT_HEX_UP, 32'd0));
    directed_q.push_back(make_req(FMT_DEC,    32'hFFFF_FFFF));
    directed_q.push_back(make_req(FMT_OCT,    32'hFFFF_FFFF));
    directed_q.push_back(make_req(FMT_HEX_LO, 32'hFFFF_FFFF));
    directed_q.push_back(make_req(FMT_HEX_UP, 32'hFFFF_FFFF));
    directed_q.push_back(make_req(FMT_DEC,    32'd1));
    directed_q.push_back(make_req(FMT_DEC,    32'd9));
    directed_q.push_back(make_req(FMT_DEC,    32'd10));
    directed_q.push_back(make_req(FMT_DEC,    32'd1_000_000_000));
    directed_q.push_back(make_req(FMT_DEC,    32'd123_456_789));
    directed_q.push_back(make_req(FMT_OCT,    32'd7));
    directed_q.push_back(make_req(FMT_OCT,    32'd8));
    directed_q.push_back(make_req(FMT_OCT,    32'h4000_0000));
    directed_q.push_back(make_req(FMT_OCT,    32'hAAAA_AAAA));
    directed_q.push_back(make_req(FMT_HEX_LO, 32'd15));
    directed_q.push_back(make_req(FMT_HEX_UP, 32'd16));
    directed_q.push_back(make_req(FMT_HEX_LO, 32'hDEAD_BEEF));
    directed_q.push_back(make_req(FMT_HEX_UP, 32'hCAFE_F00D));
    directed_q.push_back(make_req(FMT_HEX_UP, 32'h8000_0000));
    directed_q.push_back(make_req(FMT_HEX_LO, 32'h5555_5555));
    foreach (directed_q[i]) send_number(directed_q[i]);

    repeat (RANDOM_ITEMS) send_number(random_req());
    in_valid_i <= 1'b0;

    // Drain: every queued digit must arrive, then watch for strays.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/u2rt_pkg.sv
rtl/u2rt_ctrl.sv
rtl/u2rt_dpath.sv
rtl/unsigned_to_radix_text_unit.sv
tb/unsigned_to_radix_text_unit_test.sv
